@@ rtl/kth_largest_select_store_macros.svh @@
// Assertion macros used by the kth-largest select store top level.
`ifndef KTH_LARGEST_SELECT_STORE_MACROS_SVH
`define KTH_LARGEST_SELECT_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define KLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kls: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define KLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kls: next-cycle check failed");
`else
`define KLS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/kls_pkg.sv @@
// Shared constants, codes and types of the kth-largest select store.
package kls_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int RANK_W   = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_OUT_W = 7;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    // Cells per first-level select group.
    localparam int GROUP  = 8;
    localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_RANK = 2'd2
    } t_status;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic                      ins_en;
        logic signed [VALUE_W-1:0] ins_value;
        logic [CNT_W-1:0]          count;
        logic [RANK_W-1:0]         rank;
    } t_cell_ctl;

endpackage

@@ rtl/kls_cell.sv @@
// One storage cell of the sorted chain: compare, shift or insert, and rank select.
module kls_cell (
    input  logic                                i_clk,
    input  kls_pkg::t_cell_ctl                  i_ctl,
    input  logic [kls_pkg::IDX_W-1:0]           i_index,
    input  logic                                i_prev_take,
    input  logic signed [kls_pkg::VALUE_W-1:0]  i_prev_value,
    output logic                                o_take,
    output logic signed [kls_pkg::VALUE_W-1:0]  o_value,
    output logic [kls_pkg::VALUE_W-1:0]         o_sel_value
);
    import kls_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_occupied;
    logic                      w_hit;

    // Empty cells and cells holding a smaller value give way to the new one.
    assign w_occupied = CMP_W'(i_index) < CMP_W'(i_ctl.count);
    assign o_take     = !w_occupied || (r_value < i_ctl.ins_value);
    assign w_hit      = (CMP_W'(i_index) + CMP_W'(1)) == CMP_W'(i_ctl.rank);

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins_en && o_take) begin
            // Shift from the left neighbor, or take the new value at the boundary.
            n_value = i_prev_take ? i_prev_value : i_ctl.ins_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value     = r_value;
    assign o_sel_value = w_hit ? r_value : '0;

endmodule

@@ rtl/kth_largest_select_store.sv @@
// Top level of the kth-largest select store: cell chain, rank select and result port.
//
// Holds up to CAPACITY (64) signed 32-bit values in descending order in a chain of
// cells, duplicates kept. command 0 inserts value; command 1 returns the rank-th
// largest value (rank counted from 1). Every transaction gives exactly one result
// transaction with result_value, status (0 ok, 1 store full and insert dropped,
// 2 rank out of range, with result_value zero) and stored_count, the number of
// values held after that transaction. An insert updates all cells in the cycle it
// is accepted: each cell compares itself with the new value and either holds,
// takes its left neighbor's value, or takes the new value. A query selects the
// matching cell through a two-level OR tree, registered after groups of eight
// cells; the combined value is registered again in the result register. One
// transaction is in flight at a time; none is accepted while one is in the select
// stage, and a new one can be accepted in the cycle the waiting result is taken.
// No clearing pass is needed after reset: cells above the held count are ignored.
`include "kth_largest_select_store_macros.svh"

module kth_largest_select_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_command,
    input  logic signed [kls_pkg::VALUE_W-1:0] i_value,
    input  logic [kls_pkg::RANK_W-1:0]         i_rank,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [kls_pkg::VALUE_W-1:0] o_result_value,
    output logic [kls_pkg::STATUS_W-1:0]       o_status,
    output logic [kls_pkg::COUNT_OUT_W-1:0]    o_stored_count
);
    import kls_pkg::*;

    // Handshake and control state.
    logic                   r_stage;
    logic                   r_out_valid;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;

    // Select stage: group partials and the transaction's verdict.
    logic [VALUE_W-1:0]     r_grp [NGROUP];
    logic                   r_use_sel;
    t_status                r_stat;
    t_status                n_stat;

    // Result register.
    logic [VALUE_W-1:0]     r_out_value;
    t_status                r_out_status;
    logic [COUNT_OUT_W-1:0] r_out_count;

    logic                   w_accept;
    logic                   w_take_out;
    logic                   w_full;
    logic                   w_rank_bad;
    t_cell_ctl              w_ctl;
    logic                   w_take [CAPACITY];
    logic signed [VALUE_W-1:0] w_val [CAPACITY];
    logic [VALUE_W-1:0]     w_sel [CAPACITY];
    logic [VALUE_W-1:0]     w_grp [NGROUP];
    logic [VALUE_W-1:0]     w_final;

    // Stall while a transaction is being selected, or while the result waits.
    assign o_stall    = r_stage || (r_out_valid && i_stall);
    assign w_accept   = i_valid && !o_stall;
    assign w_take_out = r_out_valid && !i_stall;

    assign w_full     = r_count >= CNT_W'(CAPACITY);
    assign w_rank_bad = (i_rank == '0) || (CMP_W'(i_rank) > CMP_W'(r_count));

    always_comb begin
        n_stat  = ST_OK;
        n_count = r_count;
        if (i_command == CMD_INSERT) begin
            if (w_full) begin
                n_stat = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (w_rank_bad) begin
            n_stat = ST_RANK;
        end
    end

    assign w_ctl.ins_en    = w_accept && (i_command == CMD_INSERT) && !w_full;
    assign w_ctl.ins_value = i_value;
    assign w_ctl.count     = r_count;
    assign w_ctl.rank      = i_rank;

    // Cell chain, largest value at index zero.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            kls_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_index      (IDX_W'(gi)),
                .i_prev_take  (1'b0),
                .i_prev_value ('0),
                .o_take       (w_take[gi]),
                .o_value      (w_val[gi]),
                .o_sel_value  (w_sel[gi])
            );
        end else begin : g_body
            kls_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_index      (IDX_W'(gi)),
                .i_prev_take  (w_take[gi-1]),
                .i_prev_value (w_val[gi-1]),
                .o_take       (w_take[gi]),
                .o_value      (w_val[gi]),
                .o_sel_value  (w_sel[gi])
            );
        end
    end

    // First select level: OR of the masked cells within each group.
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            w_grp[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < CAPACITY) begin
                    w_grp[g] = w_grp[g] | w_sel[g * GROUP + j];
                end
            end
        end
    end

    // Second select level over the registered group partials.
    always_comb begin
        w_final = '0;
        for (int g = 0; g < NGROUP; g++) begin
            w_final = w_final | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_stage <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
            // Advance the select stage into the result register; drop it once taken.
            if (r_stage) begin
                r_out_valid <= 1'b1;
            end else if (w_take_out) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int g = 0; g < NGROUP; g++) begin
                r_grp[g] <= w_grp[g];
            end
            r_use_sel   <= (i_command == CMD_QUERY) && !w_rank_bad;
            r_stat      <= n_stat;
            r_out_count <= COUNT_OUT_W'(n_count);
        end
        if (r_stage) begin
            r_out_value  <= r_use_sel ? w_final : '0;
            r_out_status <= r_stat;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_stored_count = r_out_count;

    `KLS_ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `KLS_ASSERT_NEXT(a_stage_to_out, i_clk, i_rst_n, r_stage, r_out_valid)
    `KLS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ctl.ins_en, r_count == CNT_W'($past(r_count) + CNT_W'(1)))
    `KLS_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), o_result_value == '0)

endmodule
